// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the deque core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked every clock edge outside reset.
`define RBD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define RBD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define RBD_ASSERT(label, clk, rst_n, prop)
`define RBD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== rtl/rbd_pkg.sv =====
// Package: types and constants of the ring buffer deque.
`default_nettype none

package rbd_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned OccW         = 5;

  localparam logic [DataW-1:0] EmptyWord = '1;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic  en;
    kind_e kind;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rbd_in_if.sv =====
// Request channel: operation kind and push word.
`default_nettype none

interface rbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [31:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rbd_out_if.sv =====
// Result channel: status, end words, occupancy and flags.
`default_nettype none

interface rbd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;
  logic [4:0]  occupancy;
  logic        is_empty;
  logic        is_full;

  modport source (output valid, output status, output front_value, output rear_value,
                  output occupancy, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input front_value, input rear_value,
                  input occupancy, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/rbd_cell.sv =====
// One storage cell of the deque row: a word plus its occupied flag.
`default_nettype none

module rbd_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rbd_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [rbd_pkg::DataW-1:0]  push_data_i,
  input  wire logic [rbd_pkg::DataW-1:0]  left_data_i,
  input  wire logic                       left_valid_i,
  input  wire logic [rbd_pkg::DataW-1:0]  right_data_i,
  input  wire logic                       right_valid_i,
  output logic [rbd_pkg::DataW-1:0]       data_o,
  output logic                            valid_o,
  output logic                            last_o
);

  logic [rbd_pkg::DataW-1:0] data_q, data_d;
  logic                      valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.en) begin
      unique case (ctrl_i.kind)
        rbd_pkg::KIND_PUSH_FRONT: begin
          data_d  = left_data_i;
          valid_d = left_valid_i;
        end
        rbd_pkg::KIND_PUSH_REAR: begin
          // first free cell takes the word
          if (!valid_q && left_valid_i) begin
            data_d  = push_data_i;
            valid_d = 1'b1;
          end
        end
        rbd_pkg::KIND_POP_FRONT: begin
          data_d  = right_data_i;
          valid_d = right_valid_i;
        end
        rbd_pkg::KIND_POP_REAR: begin
          if (valid_q && !right_valid_i) begin
            valid_d = 1'b0;
          end
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign last_o  = valid_q & ~right_valid_i;

endmodule

`default_nettype wire

// ===== rtl/ring_buffer_deque_core.sv =====
// Deque core: a row of DEPTH cells, front word always in cell 0.
// Result: a transaction's result is registered and shown in the cycle after it is accepted.
// Throughput: one transaction per cycle while results are taken; the whole cell row
// shifts or fills in the cycle the transaction is accepted, unless it is rejected.
// Reset: occupied flags, word count and result valid clear at once; stored words
// are not cleared and no clearing pass runs, so the block is ready right after reset.
`default_nettype none
`include "assert_macros.svh"

module ring_buffer_deque_core #(
  parameter int unsigned Depth = rbd_pkg::DefaultDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rbd_in_if.sink      in_i,
  rbd_out_if.source   out_o
);

  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned DW     = rbd_pkg::DataW;

  logic [Depth-1:0]  cell_valid;
  logic [Depth-1:0]  cell_last;
  logic [DW-1:0]     cell_data [Depth];
  logic [DW-1:0]     penult_mask [Depth-1];
  logic [DW-1:0]     penult_data;

  logic [CountW-1:0] count_q, count_d;
  logic [DW-1:0]     rear_q, rear_d;

  logic              out_valid_q;
  rbd_pkg::status_e  status_q, status_d;
  logic [DW-1:0]     front_q, front_d;
  logic [DW-1:0]     rear_out_q, rear_out_d;
  logic [rbd_pkg::OccW-1:0] occ_q;
  logic              empty_q, full_q;

  logic              accept;
  rbd_pkg::kind_e    kind;
  logic              is_empty, is_full, one_left, reject;
  logic [DW-1:0]     front_cur, rear_cur;
  rbd_pkg::cell_ctrl_t ctrl;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;
  assign kind       = rbd_pkg::kind_e'(in_i.kind);

  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CountW'(Depth));
  assign one_left  = (count_q == CountW'(1));
  assign front_cur = is_empty ? rbd_pkg::EmptyWord : cell_data[0];
  assign rear_cur  = is_empty ? rbd_pkg::EmptyWord : rear_q;

  assign reject = (kind == rbd_pkg::KIND_PUSH_FRONT || kind == rbd_pkg::KIND_PUSH_REAR)
                  ? is_full : is_empty;

  assign ctrl.en   = accept & ~reject;
  assign ctrl.kind = kind;

  // cell row
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DW-1:0] left_data, right_data;
    logic          left_valid, right_valid;

    if (i == 0) begin : g_head
      assign left_data  = in_i.push_value;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    rbd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .push_data_i  (in_i.push_value),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .last_o       (cell_last[i])
    );
  end

  // word next to the rear, becomes the rear on a pop at the rear
  for (genvar i = 0; i < Depth - 1; i++) begin : g_penult
    assign penult_mask[i] = cell_last[i+1] ? cell_data[i] : '0;
  end

  always_comb begin
    penult_data = '0;
    for (int i = 0; i < Depth - 1; i++) begin
      penult_data = penult_data | penult_mask[i];
    end
  end

  always_comb begin
    count_d    = count_q;
    rear_d     = rear_q;
    status_d   = rbd_pkg::ST_DONE;
    front_d    = front_cur;
    rear_out_d = rear_cur;
    if (reject) begin
      status_d = is_full ? rbd_pkg::ST_FULL : rbd_pkg::ST_EMPTY;
    end else begin
      unique case (kind)
        rbd_pkg::KIND_PUSH_FRONT: begin
          count_d    = CountW'(count_q + 1'b1);
          front_d    = in_i.push_value;
          rear_out_d = is_empty ? in_i.push_value : rear_q;
          rear_d     = rear_out_d;
        end
        rbd_pkg::KIND_PUSH_REAR: begin
          count_d    = CountW'(count_q + 1'b1);
          front_d    = is_empty ? in_i.push_value : cell_data[0];
          rear_out_d = in_i.push_value;
          rear_d     = in_i.push_value;
        end
        rbd_pkg::KIND_POP_FRONT: begin
          count_d    = CountW'(count_q - 1'b1);
          front_d    = one_left ? rbd_pkg::EmptyWord : cell_data[1];
          rear_out_d = one_left ? rbd_pkg::EmptyWord : rear_q;
        end
        rbd_pkg::KIND_POP_REAR: begin
          count_d    = CountW'(count_q - 1'b1);
          front_d    = one_left ? rbd_pkg::EmptyWord : cell_data[0];
          rear_out_d = one_left ? rbd_pkg::EmptyWord : penult_data;
          rear_d     = penult_data;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rear_q     <= rear_d;
      status_q   <= status_d;
      front_q    <= front_d;
      rear_out_q <= rear_out_d;
      occ_q      <= rbd_pkg::OccW'(count_d);
      empty_q    <= (count_d == '0);
      full_q     <= (count_d == CountW'(Depth));
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.front_value = front_q;
  assign out_o.rear_value  = rear_out_q;
  assign out_o.occupancy   = occ_q;
  assign out_o.is_empty    = empty_q;
  assign out_o.is_full     = full_q;

  // occupied cells match the word count and sit packed from cell 0
  `RBD_ASSERT(a_count_matches_cells, clk_i, rst_ni, $countones(cell_valid) == int'(count_q))
  `RBD_ASSERT(a_cells_packed, clk_i, rst_ni, ((cell_valid + 1'b1) & cell_valid) == '0)
  // a rejected transaction leaves the row alone; when full it can only be a push
  `RBD_ASSERT(a_push_full, clk_i, rst_ni, accept && reject && is_full |=> status_q == rbd_pkg::ST_FULL)
  `RBD_ASSERT(a_reject_keeps_cells, clk_i, rst_ni, accept && reject |=> $stable(cell_valid))
  `RBD_ASSERT_NEVER(a_no_accept_on_stall, clk_i, rst_ni, accept && out_valid_q && !out_o.ready)

endmodule

`default_nettype wire

// ===== verif/ring_buffer_deque_core_test.sv =====
// Self-checking testbench for the ring buffer deque core.
module ring_buffer_deque_core_test;

  localparam int unsigned DEPTH         = rbd_pkg::DefaultDepth;
  localparam int unsigned IDX_W         = $clog2(DEPTH);
  localparam int unsigned DW            = rbd_pkg::DataW;
  localparam int unsigned OW            = rbd_pkg::OccW;
  localparam int          RANDOM_ITEMS  = 1250;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 8;

  typedef struct packed {
    rbd_pkg::status_e status;
    logic [DW-1:0]    front;
    logic [DW-1:0]    rear;
    logic [OW-1:0]    occ;
    logic             empty;
    logic             full;
  } deque_view_t;

  typedef struct {
    rbd_pkg::kind_e   kind;
    logic [DW-1:0]    word;
    bit               pinned;
    deque_view_t      view;
  } op_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rbd_in_if  in_if ();
  rbd_out_if out_if ();

  ring_buffer_deque_core #(.Depth(DEPTH)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow deque state
  logic [DW-1:0]    ring [DEPTH];
  logic [IDX_W-1:0] head_idx;
  logic [IDX_W-1:0] tail_idx;
  int unsigned      held;

  deque_view_t awaited_views[$];
  op_row_t     op_table[$];
  int          mismatches;
  bit          feed_idle;
  bit          drain_idle;
  int          quiet_cycles;

  function automatic deque_view_t deque_op_outcome(rbd_pkg::kind_e kind, logic [DW-1:0] word);
    deque_view_t v;
    v.status = rbd_pkg::ST_DONE;
    if (kind == rbd_pkg::KIND_PUSH_FRONT || kind == rbd_pkg::KIND_PUSH_REAR) begin
      if (held == DEPTH) begin
        v.status = rbd_pkg::ST_FULL;
      end else begin
        if (held == 0) begin
          head_idx = '0;
          tail_idx = '0;
          ring[0]  = word;
        end else if (kind == rbd_pkg::KIND_PUSH_FRONT) begin
          head_idx = (head_idx == 0) ? IDX_W'(DEPTH - 1) : head_idx - 1'b1;
          ring[head_idx] = word;
        end else begin
          tail_idx = (tail_idx == IDX_W'(DEPTH - 1)) ? '0 : tail_idx + 1'b1;
          ring[tail_idx] = word;
        end
        held++;
      end
    end else begin
      if (held == 0) begin
        v.status = rbd_pkg::ST_EMPTY;
      end else begin
        if (held == 1) begin
          head_idx = '0;
          tail_idx = '0;
        end else if (kind == rbd_pkg::KIND_POP_FRONT) begin
          head_idx = (head_idx == IDX_W'(DEPTH - 1)) ? '0 : head_idx + 1'b1;
        end else begin
          tail_idx = (tail_idx == 0) ? IDX_W'(DEPTH - 1) : tail_idx - 1'b1;
        end
        held--;
      end
    end
    v.front = (held == 0) ? rbd_pkg::EmptyWord : ring[head_idx];
    v.rear  = (held == 0) ? rbd_pkg::EmptyWord : ring[tail_idx];
    v.occ   = OW'(held);
    v.empty = (held == 0);
    v.full  = (held == DEPTH);
    return v;
  endfunction

  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return rbd_pkg::EmptyWord;
      3:       return '0;
      4:       return DW'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("[%0t] %s mismatch: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_row(input rbd_pkg::kind_e kind, input logic [DW-1:0] word,
                         input bit pinned, input deque_view_t view);
    op_row_t row;
    row.kind   = kind;
    row.word   = word;
    row.pinned = pinned;
    row.view   = view;
    op_table.push_back(row);
  endtask

  // Valid stays high after a transaction; the next call either keeps it or drops it.
  task automatic send_op(input rbd_pkg::kind_e kind, input logic [DW-1:0] word,
                         input bit pinned, input deque_view_t pinned_view);
    int          gap;
    deque_view_t outcome;
    gap = feed_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.push_value <= word;
    do @(posedge clk_i); while (!in_if.ready);
    outcome = deque_op_outcome(kind, word);
    awaited_views.push_back(pinned ? pinned_view : outcome);
  endtask

  task automatic settle_all();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (awaited_views.size() != 0) @(posedge clk_i);
  endtask

  // Result side
  initial begin
    int          stall;
    deque_view_t got;
    deque_view_t want;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = drain_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.status = rbd_pkg::status_e'(out_if.status);
      got.front  = out_if.front_value;
      got.rear   = out_if.rear_value;
      got.occ    = out_if.occupancy;
      got.empty  = out_if.is_empty;
      got.full   = out_if.is_full;
      if (awaited_views.size() == 0) begin
        report_mismatch("unexpected transaction", got.front, '0);
      end else begin
        want = awaited_views.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", DW'(got.status), DW'(want.status));
        if (got.front !== want.front) report_mismatch("front_value", got.front, want.front);
        if (got.rear !== want.rear) report_mismatch("rear_value", got.rear, want.rear);
        if (got.occ !== want.occ) report_mismatch("occupancy", DW'(got.occ), DW'(want.occ));
        if (got.empty !== want.empty)
          report_mismatch("is_empty", DW'(got.empty), DW'(want.empty));
        if (got.full !== want.full)
          report_mismatch("is_full", DW'(got.full), DW'(want.full));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ring_buffer_deque_core_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    deque_view_t    empty_view;
    deque_view_t    full_view;
    int             sent;
    int             burst_len;
    int             push_pct;
    rbd_pkg::kind_e kind;

    in_if.valid      = 1'b0;
    in_if.kind       = rbd_pkg::KIND_PUSH_FRONT;
    in_if.push_value = '0;
    rst_ni           = 1'b0;
    mismatches       = 0;
    quiet_cycles     = 0;
    feed_idle        = 1'b1;
    drain_idle       = 1'b1;
    held             = 0;
    head_idx         = '0;
    tail_idx         = '0;
    foreach (ring[i]) ring[i] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pops, extreme words, drain to empty, fill to full, rejects.
    empty_view = '{rbd_pkg::ST_EMPTY, rbd_pkg::EmptyWord, rbd_pkg::EmptyWord,
                   5'd0, 1'b1, 1'b0};
    full_view  = '{rbd_pkg::ST_FULL, 32'h0F0F_0F0F, 32'h0E0E_0E0E, OW'(DEPTH), 1'b0, 1'b1};
    add_row(rbd_pkg::KIND_POP_FRONT, 32'h1234_5678, 1'b1, empty_view);
    add_row(rbd_pkg::KIND_POP_REAR, 32'h8765_4321, 1'b1, empty_view);
    add_row(rbd_pkg::KIND_PUSH_FRONT, 32'h8000_0000, 1'b1,
            '{rbd_pkg::ST_DONE, 32'h8000_0000, 32'h8000_0000, 5'd1, 1'b0, 1'b0});
    add_row(rbd_pkg::KIND_PUSH_REAR, 32'h7FFF_FFFF, 1'b1,
            '{rbd_pkg::ST_DONE, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0, 1'b0});
    add_row(rbd_pkg::KIND_POP_REAR, '0, 1'b1,
            '{rbd_pkg::ST_DONE, 32'h8000_0000, 32'h8000_0000, 5'd1, 1'b0, 1'b0});
    add_row(rbd_pkg::KIND_POP_FRONT, '0, 1'b1,
            '{rbd_pkg::ST_DONE, rbd_pkg::EmptyWord, rbd_pkg::EmptyWord, 5'd0, 1'b1, 1'b0});
    // Stored all-ones word reads the same as an empty end
    add_row(rbd_pkg::KIND_PUSH_REAR, rbd_pkg::EmptyWord, 1'b1,
            '{rbd_pkg::ST_DONE, rbd_pkg::EmptyWord, rbd_pkg::EmptyWord, 5'd1, 1'b0, 1'b0});
    for (int i = 1; i < DEPTH; i++) begin
      add_row((i % 2) ? rbd_pkg::KIND_PUSH_FRONT : rbd_pkg::KIND_PUSH_REAR,
              DW'(32'h0101_0101 * i), 1'b0, '0);
    end
    add_row(rbd_pkg::KIND_PUSH_FRONT, 32'hDEAD_BEEF, 1'b1, full_view);
    add_row(rbd_pkg::KIND_PUSH_REAR, 32'hCAFE_F00D, 1'b1, full_view);

    foreach (op_table[i]) begin
      send_op(op_table[i].kind, op_table[i].word, op_table[i].pinned, op_table[i].view);
    end
    settle_all();

    // Random bursts, each leaning toward filling, draining or churning.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len  = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      feed_idle  = ($urandom_range(0, 3) != 0);
      drain_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) settle_all();
      for (int n = 0; n < burst_len; n++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          kind = $urandom_range(0, 1) ? rbd_pkg::KIND_PUSH_REAR : rbd_pkg::KIND_PUSH_FRONT;
        end else begin
          kind = $urandom_range(0, 1) ? rbd_pkg::KIND_POP_REAR : rbd_pkg::KIND_POP_FRONT;
        end
        send_op(kind, pick_word(), 1'b0, '0);
        sent++;
      end
    end

    settle_all();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ring_buffer_deque_core_test: PASS");
    end else begin
      $display("ring_buffer_deque_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== ring_buffer_deque_core.f =====
+incdir+rtl
rtl/rbd_pkg.sv
rtl/rbd_in_if.sv
rtl/rbd_out_if.sv
rtl/rbd_cell.sv
rtl/ring_buffer_deque_core.sv
verif/ring_buffer_deque_core_test.sv
